[rtl/bti_pkg.sv]
// Shared types, codes and sizes for the breakpoint table interpolator.
`default_nettype none

package bti_pkg;

   // Table size and the widths that follow from it.
   localparam int MaxPoints = 16;
   localparam int CountW    = $clog2(MaxPoints + 1);
   localparam int IndexW    = $clog2(MaxPoints);
   localparam int DivW      = 32;
   localparam int QuoW      = 17;
   localparam int DivCntW   = $clog2(DivW);

   // Register index of the interpolation mode register.
   localparam int RegInterpMode = 0;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_EMPTY   = 2'd1,
      STAT_NOTRISE = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   // Query token that travels along the row of cells.
   typedef struct packed {
      logic               valid;
      logic               below;
      logic               have_hi;
      logic signed [15:0] pos;
      logic signed [15:0] lo_x;
      logic signed [15:0] lo_y;
      logic signed [15:0] hi_x;
      logic signed [15:0] hi_y;
   } token_type;

   // Write of one breakpoint into a cell.
   typedef struct packed {
      logic               en;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } point_wr_type;

endpackage

`default_nettype wire

[rtl/breakpoint_table_interpolator.sv]
// Top level of the breakpoint table interpolator: control, cell row and divider.
//
//   channel   direction  handshake             contents
//   req_      in         tvalid/tready         tuser op, tdata pos and level
//   rsp_      out        tvalid/tready         tuser status, tdata value and count
//   csr_      in         psel/penable/pready   interp_mode at address 0
//
// Load, clear and unused ops go from idle straight to the finish state. A query on a
// filled table passes its token along the row of 16 cells, then takes a multiply and
// the one-bit-per-cycle divider (linear answers only; step answers skip these).
// Reset is synchronous and empties the table; mode returns to linear.
// One item is worked on at a time; a finished result waits in the output register
// while the next item is taken in.
`default_nettype none

module breakpoint_table_interpolator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // op
   input  wire  [31:0] req_tdata,   // pos, level
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [1:0]  rsp_tuser,   // status
   output logic [23:0] rsp_tdata,   // value, point_count, zero fill
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bti_pkg::state_type              state_ff, state_in;
   logic [bti_pkg::CountW-1:0]      count_ff, count_in;
   logic signed [15:0]              last_x_ff, last_x_in;
   logic                            mode_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]              rsp_value_ff, rsp_value_in;
   bti_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [bti_pkg::CountW-1:0]      rsp_count_ff, rsp_count_in;
   logic signed [15:0]              val_ff, val_in;
   bti_pkg::status_type             stat_ff, stat_in;
   logic signed [15:0]              lo_y_ff, lo_y_in;
   logic [15:0]                     dx_ff, dx_in;
   logic signed [16:0]              dy_ff, dy_in;
   logic [15:0]                     t_ff, t_in;
   logic                            neg_ff, neg_in;

   bti_pkg::op_type                 op;
   logic signed [15:0]              pos;
   logic signed [15:0]              level;
   logic                            accept;
   logic                            load_ok;
   bti_pkg::token_type              inject;
   bti_pkg::token_type              chain [bti_pkg::MaxPoints+1];
   bti_pkg::token_type              done_tok;
   logic signed [16:0]              dx_full, dy_full, t_full;
   logic [15:0]                     dy_mag;
   logic [bti_pkg::DivW-1:0]        product;
   logic                            div_start, div_busy, div_done;
   logic [bti_pkg::QuoW-1:0]        quo;
   logic signed [17:0]              q_signed;
   logic signed [17:0]              sum;

   assign op     = bti_pkg::op_type'(req_tuser);
   assign pos    = req_tdata[15:0];
   assign level  = req_tdata[31:16];
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == bti_pkg::S_IDLE);

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'(4 * bti_pkg::RegInterpMode)) ? {31'd0, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == 3'(4 * bti_pkg::RegInterpMode)) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   // Load acceptance and query injection.
   assign load_ok = accept && op == bti_pkg::OP_LOAD &&
                    count_ff != bti_pkg::CountW'(bti_pkg::MaxPoints) &&
                    (count_ff == '0 || pos > last_x_ff);

   always_comb begin
      inject       = '0;
      inject.valid = accept && op == bti_pkg::OP_QUERY && count_ff != '0;
      inject.pos   = pos;
   end

   assign chain[0] = inject;

   // Row of breakpoint cells.
   for (genvar i = 0; i < bti_pkg::MaxPoints; i++) begin : g_cell
      bti_pkg::point_wr_type wr;
      always_comb begin
         wr.en = load_ok && count_ff[bti_pkg::IndexW-1:0] == bti_pkg::IndexW'(i);
         wr.x  = pos;
         wr.y  = level;
      end
      bti_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .is_first (i == 0),
         .active   (count_ff > bti_pkg::CountW'(i)),
         .wr       (wr),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   assign done_tok = chain[bti_pkg::MaxPoints];

   // Segment differences for the interpolation.
   assign dx_full = 17'(done_tok.hi_x) - 17'(done_tok.lo_x);
   assign dy_full = 17'(done_tok.hi_y) - 17'(done_tok.lo_y);
   assign t_full  = 17'(done_tok.pos) - 17'(done_tok.lo_x);
   assign dy_mag  = dy_ff[16] ? 16'(-dy_ff) : dy_ff[15:0];
   assign product = 32'(dy_mag) * 32'(t_ff);
   assign div_start = (state_ff == bti_pkg::S_MUL);

   bti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (dx_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quo)
   );

   assign q_signed = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign sum      = 18'(lo_y_ff) + q_signed;

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      last_x_in     = last_x_ff;
      val_in        = val_ff;
      stat_in       = stat_ff;
      lo_y_in       = lo_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      t_in          = t_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         bti_pkg::S_IDLE: begin
            if (accept) begin
               val_in   = '0;
               stat_in  = bti_pkg::STAT_OK;
               state_in = bti_pkg::S_FINISH;
               case (op)
                  bti_pkg::OP_LOAD: begin
                     if (count_ff == bti_pkg::CountW'(bti_pkg::MaxPoints)) begin
                        stat_in = bti_pkg::STAT_FULL;
                     end else if (!load_ok) begin
                        stat_in = bti_pkg::STAT_NOTRISE;
                     end else begin
                        count_in  = count_ff + 1'b1;
                        last_x_in = pos;
                     end
                  end
                  bti_pkg::OP_QUERY: begin
                     if (count_ff == '0) begin
                        stat_in = bti_pkg::STAT_EMPTY;
                     end else begin
                        state_in = bti_pkg::S_SCAN;
                     end
                  end
                  bti_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bti_pkg::S_SCAN: begin
            if (done_tok.valid) begin
               lo_y_in = done_tok.lo_y;
               dx_in   = dx_full[15:0];
               dy_in   = dy_full;
               t_in    = t_full[15:0];
               if (!mode_ff || done_tok.below || !done_tok.have_hi ||
                   done_tok.pos == done_tok.lo_x) begin
                  val_in   = done_tok.lo_y;
                  state_in = bti_pkg::S_FINISH;
               end else begin
                  state_in = bti_pkg::S_MUL;
               end
            end
         end
         bti_pkg::S_MUL: begin
            neg_in   = dy_ff[16];
            state_in = bti_pkg::S_DIV;
         end
         bti_pkg::S_DIV: begin
            if (div_done) begin
               val_in   = sum[15:0];
               state_in = bti_pkg::S_FINISH;
            end
         end
         bti_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = val_ff;
               rsp_status_in = stat_ff;
               rsp_count_in  = count_ff;
               state_in      = bti_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bti_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bti_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_x_ff     <= last_x_in;
      val_ff        <= val_in;
      stat_ff       <= stat_in;
      lo_y_ff       <= lo_y_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      t_ff          <= t_in;
      neg_ff        <= neg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Result channel; the count is captured with the result so that a waiting
   // result keeps its own count while the next item is taken in.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_count_ff, rsp_value_ff};

   // Checks on the control logic.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bti_pkg::CountW'(bti_pkg::MaxPoints))
      else $error("breakpoint count above table size");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == bti_pkg::S_IDLE |-> !div_busy)
      else $error("divider busy while sequencer idle");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == bti_pkg::STAT_EMPTY |-> rsp_value_ff == '0)
      else $error("empty-table result carries a value");

   a_token_scan: assert property (@(posedge clock) disable iff (reset)
      done_tok.valid |-> state_ff == bti_pkg::S_SCAN)
      else $error("query token left the row outside a scan");

endmodule

`default_nettype wire

[rtl/bti_cell.sv]
// One cell of the breakpoint row: holds one point and refines the passing query token.
`default_nettype none

module bti_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  is_first,
   input  wire                  active,
   input  bti_pkg::point_wr_type wr,
   input  bti_pkg::token_type   tok_in,
   output bti_pkg::token_type   tok_out
);

   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   bti_pkg::token_type tok_ff;
   bti_pkg::token_type tok_in_next;

   // Breakpoint storage.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         x_ff <= wr.x;
         y_ff <= wr.y;
      end
   end

   // The first cell always seeds the left point; later cells move it right or set the right point.
   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && active) begin
         if (is_first) begin
            tok_in_next.lo_x    = x_ff;
            tok_in_next.lo_y    = y_ff;
            tok_in_next.below   = (x_ff > tok_in.pos);
            tok_in_next.have_hi = 1'b0;
         end else if (x_ff <= tok_in.pos) begin
            tok_in_next.lo_x    = x_ff;
            tok_in_next.lo_y    = y_ff;
            tok_in_next.below   = 1'b0;
            tok_in_next.have_hi = 1'b0;
         end else if (!tok_in.have_hi) begin
            tok_in_next.hi_x    = x_ff;
            tok_in_next.hi_y    = y_ff;
            tok_in_next.have_hi = 1'b1;
         end
      end
   end

   // Hand the token to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

[rtl/bti_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module bti_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [bti_pkg::DivW-1:0]      dividend,
   input  wire [15:0]                   divisor,
   output logic                         busy,
   output logic                         done,
   output logic [bti_pkg::QuoW-1:0]     quotient
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [bti_pkg::DivCntW-1:0]  cnt_ff, cnt_in;
   logic [15:0]                  rem_ff, rem_in;
   logic [bti_pkg::DivW-1:0]     quo_ff, quo_in;
   logic [15:0]                  dvs_ff, dvs_in;
   logic [16:0]                  trial;

   // One shift and subtract step.
   always_comb begin
      trial   = {rem_ff, quo_ff[bti_pkg::DivW-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[bti_pkg::DivW-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[bti_pkg::DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bti_pkg::DivCntW'(bti_pkg::DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff[bti_pkg::QuoW-1:0];

endmodule

`default_nettype wire
